### rtl/stepper_position_speed_loop_unit_macros.svh
// Assertion macros shared by the checker of the stepper position and speed loop.
// Needs nothing but a clock and an active-low reset in the using scope.
`ifndef STEPPER_POSITION_SPEED_LOOP_UNIT_MACROS_SVH
`define STEPPER_POSITION_SPEED_LOOP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SPSL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SPSL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/spsl_pkg.sv
// Package of the stepper position and speed loop: opcodes, register map,
// configuration record, reset values and the shared arithmetic unit handshake.
package spsl_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int TIMER_BITS_DEF = 16;
    localparam int MDU_W          = 64;
    localparam int MUL_STEPS      = 32;
    localparam int CFG_AW         = 5;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_SET_ANGLE = 3'd1,
        OP_SET_SPEED = 3'd2,
        OP_MOVE_BY   = 3'd3,
        OP_STOP      = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        REG_ANGLE_OFFSET  = 3'd0,
        REG_POS_TOL       = 3'd1,
        REG_POS_GAIN      = 3'd2,
        REG_MAX_SPEED     = 3'd3,
        REG_STEP_LIMIT    = 3'd4,
        REG_MIN_SPEED     = 3'd5,
        REG_CLOCK_CONST   = 3'd6,
        REG_BASE_PERIOD   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] angle_offset;
        logic [30:0] position_tolerance;
        logic [15:0] position_gain;
        logic [30:0] max_speed;
        logic [30:0] speed_step_limit;
        logic [30:0] min_speed;
        logic [31:0] step_clock_constant;
        logic [15:0] base_period;
    } t_cfg;

    localparam logic [31:0] RST_ANGLE_OFFSET  = 32'd0;
    localparam logic [30:0] RST_POS_TOL       = 31'd65536;
    localparam logic [15:0] RST_POS_GAIN      = 16'd1311;
    localparam logic [30:0] RST_MAX_SPEED     = 31'd327680;
    localparam logic [30:0] RST_STEP_LIMIT    = 31'd6554;
    localparam logic [30:0] RST_MIN_SPEED     = 31'd655;
    localparam logic [31:0] RST_CLOCK_CONST   = 32'd100000;
    localparam logic [15:0] RST_BASE_PERIOD   = 16'd10;

    typedef enum logic {
        MDU_MUL = 1'b0,
        MDU_DIV = 1'b1
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_rsp;

endpackage

### rtl/spsl_if.sv
// Valid/ready channel interfaces for commands in and timer settings out.
// Depends on spsl_pkg for the default timer width.
interface spsl_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] value;
    logic [31:0] measured_angle;

    modport source (output valid, opcode, value, measured_angle, input ready);
    modport sink   (input valid, opcode, value, measured_angle, output ready);
endinterface

interface spsl_out_if #(
    parameter int TIMER_BITS = spsl_pkg::TIMER_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  timer_run;
    logic                  direction;
    logic [TIMER_BITS-1:0] prescaler_value;
    logic [TIMER_BITS-1:0] autoreload_value;
    logic [TIMER_BITS-1:0] compare_value;
    logic [31:0]           speed_command;
    logic                  saturated;

    modport source (output valid, timer_run, direction, prescaler_value, autoreload_value,
                    compare_value, speed_command, saturated, input ready);
    modport sink   (input valid, timer_run, direction, prescaler_value, autoreload_value,
                    compare_value, speed_command, saturated, output ready);
endinterface

### rtl/spsl_cfg.sv
// APB-style configuration register file of the stepper position and speed loop.
// Depends on spsl_pkg for the register map and reset values.
module spsl_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [spsl_pkg::CFG_AW-1:0]   i_paddr,
    input  logic [31:0]                   i_pwdata,
    output logic [31:0]                   o_prdata,
    output spsl_pkg::t_cfg                o_cfg
);

    spsl_pkg::t_cfg     r_cfg;
    spsl_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx = spsl_pkg::t_reg_idx'(i_paddr[spsl_pkg::CFG_AW-1:2]);
    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_offset        <= spsl_pkg::RST_ANGLE_OFFSET;
            r_cfg.position_tolerance  <= spsl_pkg::RST_POS_TOL;
            r_cfg.position_gain       <= spsl_pkg::RST_POS_GAIN;
            r_cfg.max_speed           <= spsl_pkg::RST_MAX_SPEED;
            r_cfg.speed_step_limit    <= spsl_pkg::RST_STEP_LIMIT;
            r_cfg.min_speed           <= spsl_pkg::RST_MIN_SPEED;
            r_cfg.step_clock_constant <= spsl_pkg::RST_CLOCK_CONST;
            r_cfg.base_period         <= spsl_pkg::RST_BASE_PERIOD;
        end else if (w_wr) begin
            unique case (w_idx)
                spsl_pkg::REG_ANGLE_OFFSET:  r_cfg.angle_offset        <= i_pwdata;
                spsl_pkg::REG_POS_TOL:       r_cfg.position_tolerance  <= i_pwdata[30:0];
                spsl_pkg::REG_POS_GAIN:      r_cfg.position_gain       <= i_pwdata[15:0];
                spsl_pkg::REG_MAX_SPEED:     r_cfg.max_speed           <= i_pwdata[30:0];
                spsl_pkg::REG_STEP_LIMIT:    r_cfg.speed_step_limit    <= i_pwdata[30:0];
                spsl_pkg::REG_MIN_SPEED:     r_cfg.min_speed           <= i_pwdata[30:0];
                spsl_pkg::REG_CLOCK_CONST:   r_cfg.step_clock_constant <= i_pwdata;
                spsl_pkg::REG_BASE_PERIOD:   r_cfg.base_period         <= i_pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            spsl_pkg::REG_ANGLE_OFFSET:  o_prdata = r_cfg.angle_offset;
            spsl_pkg::REG_POS_TOL:       o_prdata = {1'b0, r_cfg.position_tolerance};
            spsl_pkg::REG_POS_GAIN:      o_prdata = {16'd0, r_cfg.position_gain};
            spsl_pkg::REG_MAX_SPEED:     o_prdata = {1'b0, r_cfg.max_speed};
            spsl_pkg::REG_STEP_LIMIT:    o_prdata = {1'b0, r_cfg.speed_step_limit};
            spsl_pkg::REG_MIN_SPEED:     o_prdata = {1'b0, r_cfg.min_speed};
            spsl_pkg::REG_CLOCK_CONST:   o_prdata = r_cfg.step_clock_constant;
            spsl_pkg::REG_BASE_PERIOD:   o_prdata = {16'd0, r_cfg.base_period};
        endcase
    end

endmodule

### rtl/spsl_mdu.sv
// Shared iterative multiply/divide unit: one adder, shift-add multiply over
// 32 multiplier bits and restoring divide over 64 dividend bits. Uses spsl_pkg.
module spsl_mdu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spsl_pkg::t_mdu_req            i_req,
    input  logic [spsl_pkg::MDU_W-1:0]    i_a,
    input  logic [spsl_pkg::MDU_W-1:0]    i_b,
    output spsl_pkg::t_mdu_rsp            o_rsp,
    output logic [spsl_pkg::MDU_W-1:0]    o_result
);

    localparam int W  = spsl_pkg::MDU_W;
    localparam int CW = $clog2(W);

    logic              r_busy;
    logic              r_done;
    spsl_pkg::t_mdu_op r_op;
    logic [CW-1:0]     r_cnt;
    logic [W-1:0]      r_acc;
    logic [W-1:0]      r_a;
    logic [W-1:0]      r_b;
    logic [W-1:0]      r_rem;

    logic [W+1:0] w_x;
    logic [W+1:0] w_y;
    logic [W+1:0] w_sum;
    logic         w_sub;
    logic         w_ge;
    logic         w_last;

    // Multiply adds the shifted multiplicand; divide trial-subtracts the divisor.
    assign w_sub  = (r_op == spsl_pkg::MDU_DIV);
    assign w_x    = w_sub ? {1'b0, r_rem, r_a[W-1]} : {2'b00, r_acc};
    assign w_y    = w_sub ? {2'b00, r_b} : {2'b00, r_a};
    assign w_sum  = w_x + (w_sub ? ~w_y : w_y) + {{(W+1){1'b0}}, w_sub};
    assign w_ge   = !w_sum[W+1];
    assign w_last = w_sub ? (r_cnt == CW'(W - 1)) : (r_cnt == CW'(spsl_pkg::MUL_STEPS - 1));

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_result   = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= '0;
            r_acc <= '0;
            r_rem <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            r_a   <= r_a << 1;
            if (w_sub) begin
                r_acc <= {r_acc[W-2:0], w_ge};
                r_rem <= w_ge ? w_sum[W-1:0] : {r_rem[W-2:0], r_a[W-1]};
            end else begin
                r_b <= r_b >> 1;
                if (r_b[0]) begin
                    r_acc <= w_sum[W-1:0];
                end
            end
        end
    end

endmodule

### rtl/stepper_position_speed_loop_unit.sv
// Top level of the stepper position and speed loop with its command sequencer.
// Depends on spsl_pkg, spsl_if, spsl_cfg and spsl_mdu.
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+---------------------------------------
//  i_cmd    | in  | valid/ready               | opcode, value, measured_angle
//  o_res    | out | valid/ready               | timer_run .. saturated
//  apb      | in  | psel/penable/pwrite       | paddr, pwdata (prdata back, pready = 1)
//
// Set-angle, set-speed and move-by commands complete in the cycle of their transfer.
// An update tick runs prepare, then gain multiply and goal in position mode outside
// the tolerance band, then slew, apply and check; unless the timer stops, the shared
// unit multiplies and divides; widening the period adds two multiplies and a divide.
// A stop goes straight to the final state that builds its result. i_cmd is not ready
// while a command is in work. A finished result waits in the output register; the next
// command is taken meanwhile, and a full output register holds the sequencer in place.
// Reset is synchronous and active low; there is no clearing pass.
module stepper_position_speed_loop_unit #(
    parameter int FRAC_BITS  = spsl_pkg::FRAC_BITS_DEF,
    parameter int TIMER_BITS = spsl_pkg::TIMER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    spsl_in_if.sink                       i_cmd,
    spsl_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spsl_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int W = spsl_pkg::MDU_W;

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_PREP    = 17'h00002,
        S_W_GMUL  = 17'h00004,
        S_GOAL    = 17'h00008,
        S_SLEW    = 17'h00010,
        S_APPLY   = 17'h00020,
        S_CHECK   = 17'h00040,
        S_W_DMUL  = 17'h00080,
        S_L_DIV1  = 17'h00100,
        S_W_DIV1  = 17'h00200,
        S_L_WID   = 17'h00400,
        S_W_WMUL  = 17'h00800,
        S_L_DEN2  = 17'h01000,
        S_W_DMUL2 = 17'h02000,
        S_L_DIV2  = 17'h04000,
        S_W_DIV2  = 17'h08000,
        S_FIN     = 17'h10000
    } t_state;

    function automatic logic [31:0] sat32(input logic [32:0] s);
        if (s[32] != s[31]) begin
            return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return s[31:0];
    endfunction

    spsl_pkg::t_cfg     w_cfg;
    spsl_pkg::t_mdu_req w_req;
    spsl_pkg::t_mdu_rsp w_rsp;
    logic [W-1:0]       w_ma;
    logic [W-1:0]       w_mb;
    logic [W-1:0]       w_res;

    t_state r_state;
    t_state n_state;

    logic        r_pos_mode;
    logic [31:0] r_pc;
    logic [31:0] r_goal;
    logic [31:0] r_last;
    logic [31:0] r_meas;
    logic        r_goal_neg;
    logic [31:0] r_delta;
    logic [31:0] r_cmd;
    logic [31:0] r_mag;
    logic        r_dir;
    logic        r_stop;
    logic [W-1:0] r_period;

    logic                  r_out_valid;
    logic                  r_o_run;
    logic                  r_o_dir;
    logic [TIMER_BITS-1:0] r_o_psc;
    logic [TIMER_BITS-1:0] r_o_arr;
    logic [TIMER_BITS-1:0] r_o_cmp;
    logic [31:0]           r_o_speed;
    logic                  r_o_sat;

    logic         w_in_xfer;
    logic         w_out_free;
    logic [15:0]  w_bp;
    logic [W-1:0] w_num;
    logic [W-1:0] w_tmax;
    logic [32:0]  w_d1;
    logic [32:0]  w_d2;
    logic [32:0]  w_abs_err;
    logic         w_in_band;
    logic [W-1:0] w_mrnd;
    logic [31:0]  w_qmag;
    logic [31:0]  w_goal;
    logic [32:0]  w_dspd;
    logic [32:0]  w_lim;
    logic [31:0]  w_delta;
    logic [32:0]  w_cmd33;
    logic [32:0]  w_min33;
    logic         w_stopped;
    logic [31:0]  w_mag;
    logic [31:0]  w_base;
    logic         w_widen;
    logic [W-1:0] w_pm1;
    logic [W-1:0] w_arr;
    logic [W-1:0] w_cmp;
    logic [TIMER_BITS-1:0] w_psc_o;
    logic [TIMER_BITS-1:0] w_arr_o;
    logic [TIMER_BITS-1:0] w_cmp_o;
    logic         w_sat;

    spsl_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    spsl_mdu u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_a      (w_ma),
        .i_b      (w_mb),
        .o_rsp    (w_rsp),
        .o_result (w_res)
    );

    assign pready      = 1'b1;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_in_xfer   = i_cmd.valid && i_cmd.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;

    assign o_res.valid            = r_out_valid;
    assign o_res.timer_run        = r_o_run;
    assign o_res.direction        = r_o_dir;
    assign o_res.prescaler_value  = r_o_psc;
    assign o_res.autoreload_value = r_o_arr;
    assign o_res.compare_value    = r_o_cmp;
    assign o_res.speed_command    = r_o_speed;
    assign o_res.saturated        = r_o_sat;

    assign w_bp   = (w_cfg.base_period == 16'd0) ? 16'd1 : w_cfg.base_period;
    assign w_num  = W'(w_cfg.step_clock_constant) << FRAC_BITS;
    assign w_tmax = (W'(1) << TIMER_BITS) - W'(1);

    // Position error magnitude from two parallel subtractions.
    assign w_d1      = {r_meas[31], r_meas} - {r_pc[31], r_pc};
    assign w_d2      = {r_pc[31], r_pc} - {r_meas[31], r_meas};
    assign w_abs_err = w_d1[32] ? w_d2 : w_d1;
    assign w_in_band = (w_abs_err < {2'b00, w_cfg.position_tolerance});

    // Round half away from zero on the magnitude, then clamp to the speed limit.
    assign w_mrnd = (w_res + (W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign w_qmag = (w_mrnd > W'(w_cfg.max_speed)) ? {1'b0, w_cfg.max_speed} : w_mrnd[31:0];
    assign w_goal = r_goal_neg ? (32'd0 - w_qmag) : w_qmag;

    assign w_dspd = {r_goal[31], r_goal} - {r_last[31], r_last};
    assign w_lim  = {2'b00, w_cfg.speed_step_limit};
    always_comb begin
        if ($signed(w_dspd) > $signed(w_lim)) begin
            w_delta = {1'b0, w_cfg.speed_step_limit};
        end else if ($signed(w_dspd) < -$signed(w_lim)) begin
            w_delta = 32'd0 - {1'b0, w_cfg.speed_step_limit};
        end else begin
            w_delta = w_dspd[31:0];
        end
    end

    assign w_cmd33   = {r_cmd[31], r_cmd};
    assign w_min33   = {2'b00, w_cfg.min_speed};
    assign w_stopped = ($signed(w_cmd33) >= -$signed(w_min33)) &&
                       ($signed(w_cmd33) <= $signed(w_min33));
    assign w_mag     = r_cmd[31] ? (32'd0 - r_cmd) : r_cmd;

    assign w_base  = r_pos_mode ? r_pc : i_cmd.measured_angle;
    assign w_widen = (w_res > w_tmax);

    // Timer fields with clamping to the timer width.
    assign w_pm1 = w_res - W'(1);
    assign w_arr = r_period - W'(1);
    assign w_cmp = r_period >> 1;
    always_comb begin
        w_sat = 1'b0;
        if (w_res == '0) begin
            w_psc_o = '0;
            w_sat   = 1'b1;
        end else if (w_pm1 > w_tmax) begin
            w_psc_o = '1;
            w_sat   = 1'b1;
        end else begin
            w_psc_o = w_pm1[TIMER_BITS-1:0];
        end
        if (w_arr > w_tmax) begin
            w_arr_o = '1;
            w_sat   = 1'b1;
        end else begin
            w_arr_o = w_arr[TIMER_BITS-1:0];
        end
        if (w_cmp > w_tmax) begin
            w_cmp_o = '1;
            w_sat   = 1'b1;
        end else begin
            w_cmp_o = w_cmp[TIMER_BITS-1:0];
        end
    end

    // Sequencer: next state and requests to the shared unit.
    always_comb begin
        n_state   = r_state;
        w_req     = '{start: 1'b0, op: spsl_pkg::MDU_MUL};
        w_ma      = '0;
        w_mb      = '0;
        unique case (r_state) inside
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (i_cmd.opcode == spsl_pkg::OP_TICK) begin
                        n_state = S_PREP;
                    end else if (i_cmd.opcode == spsl_pkg::OP_STOP) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_PREP: begin
                if (!r_pos_mode || w_in_band) begin
                    n_state = S_SLEW;
                end else begin
                    w_req   = '{start: 1'b1, op: spsl_pkg::MDU_MUL};
                    w_ma    = W'(w_abs_err);
                    w_mb    = W'(w_cfg.position_gain);
                    n_state = S_W_GMUL;
                end
            end
            S_W_GMUL:  if (w_rsp.done) n_state = S_GOAL;
            S_GOAL:    n_state = S_SLEW;
            S_SLEW:    n_state = S_APPLY;
            S_APPLY:   n_state = S_CHECK;
            S_CHECK: begin
                if (w_stopped) begin
                    n_state = S_FIN;
                end else begin
                    w_req   = '{start: 1'b1, op: spsl_pkg::MDU_MUL};
                    w_ma    = W'(w_mag);
                    w_mb    = W'(w_bp);
                    n_state = S_W_DMUL;
                end
            end
            S_W_DMUL:  if (w_rsp.done) n_state = S_L_DIV1;
            S_L_DIV1, S_L_DIV2: begin
                w_req   = '{start: 1'b1, op: spsl_pkg::MDU_DIV};
                w_ma    = (w_num << 1) + w_res;
                w_mb    = w_res << 1;
                n_state = (r_state == S_L_DIV1) ? S_W_DIV1 : S_W_DIV2;
            end
            S_W_DIV1:  if (w_rsp.done) n_state = S_L_WID;
            S_L_WID: begin
                if (w_widen) begin
                    w_req   = '{start: 1'b1, op: spsl_pkg::MDU_MUL};
                    w_ma    = (w_res >> TIMER_BITS) + W'(1);
                    w_mb    = W'(w_bp);
                    n_state = S_W_WMUL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_W_WMUL:  if (w_rsp.done) n_state = S_L_DEN2;
            S_L_DEN2: begin
                w_req   = '{start: 1'b1, op: spsl_pkg::MDU_MUL};
                w_ma    = w_res;
                w_mb    = W'(r_mag);
                n_state = S_W_DMUL2;
            end
            S_W_DMUL2: if (w_rsp.done) n_state = S_L_DIV2;
            S_W_DIV2:  if (w_rsp.done) n_state = S_FIN;
            S_FIN:     if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos_mode  <= 1'b1;
            r_pc        <= '0;
            r_goal      <= '0;
            r_last      <= '0;
        end else begin
            r_state <= n_state;
            // A new result may load in the same cycle as the transfer of the old one.
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_meas <= i_cmd.measured_angle;
                        case (i_cmd.opcode)
                            spsl_pkg::OP_SET_ANGLE: begin
                                r_pos_mode <= 1'b1;
                                r_pc <= sat32({i_cmd.value[31], i_cmd.value} +
                                        {w_cfg.angle_offset[31], w_cfg.angle_offset});
                            end
                            spsl_pkg::OP_SET_SPEED: begin
                                r_pos_mode <= 1'b0;
                                r_goal     <= i_cmd.value;
                            end
                            spsl_pkg::OP_MOVE_BY: begin
                                // Leaving speed mode restarts from the measured position.
                                r_pos_mode <= 1'b1;
                                r_pc <= sat32({w_base[31], w_base} +
                                        {i_cmd.value[31], i_cmd.value});
                            end
                            spsl_pkg::OP_STOP: begin
                                r_last <= '0;
                                r_goal <= '0;
                                r_pc   <= i_cmd.measured_angle;
                                r_cmd  <= '0;
                                r_stop <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PREP: begin
                    r_goal_neg <= !w_d1[32] && (w_d1 != 33'd0);
                    if (r_pos_mode && w_in_band) begin
                        r_goal <= '0;
                    end
                end
                S_GOAL:  r_goal  <= w_goal;
                S_SLEW:  r_delta <= w_delta;
                S_APPLY: begin
                    r_last <= r_last + r_delta;
                    r_cmd  <= r_last + r_delta;
                end
                S_CHECK: begin
                    r_stop <= w_stopped;
                    r_mag  <= w_mag;
                    r_dir  <= !r_cmd[31];
                end
                S_L_WID: begin
                    if (!w_widen) begin
                        r_period <= W'(w_bp);
                    end
                end
                S_L_DEN2: r_period <= w_res;
                S_FIN: begin
                    if (w_out_free) begin
                        r_o_speed   <= r_cmd;
                        if (r_stop) begin
                            r_o_run <= 1'b0;
                            r_o_dir <= 1'b0;
                            r_o_psc <= '0;
                            r_o_arr <= '0;
                            r_o_cmp <= '0;
                            r_o_sat <= 1'b0;
                        end else begin
                            r_o_run <= 1'b1;
                            r_o_dir <= r_dir;
                            r_o_psc <= w_psc_o;
                            r_o_arr <= w_arr_o;
                            r_o_cmp <= w_cmp_o;
                            r_o_sat <= w_sat;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### rtl/spsl_checker.sv
// Port-level checker for the stepper position and speed loop, bound to the top.
// Depends on spsl_pkg and the assertion macro header.
`include "stepper_position_speed_loop_unit_macros.svh"

module spsl_checker #(
    parameter int TIMER_BITS = spsl_pkg::TIMER_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic [2:0]            i_in_opcode,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_timer_run,
    input logic                  i_direction,
    input logic [TIMER_BITS-1:0] i_psc,
    input logic [TIMER_BITS-1:0] i_arr,
    input logic [TIMER_BITS-1:0] i_cmp,
    input logic                  i_saturated
);

    // A result stays offered until its transfer.
    `SPSL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result withdrawn before transfer")

    // A stop keeps the block busy for the cycle that builds its result.
    `SPSL_ASSERT_NXT(a_stop_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_opcode == spsl_pkg::OP_STOP), !i_in_ready, "command taken while stop result pending")

    // A stopped timer carries no timer settings.
    `SPSL_ASSERT_IMP(a_stopped_zero, i_clk, i_rst_n, i_out_valid && !i_timer_run, !i_direction && (i_psc == '0) && (i_arr == '0) && (i_cmp == '0) && !i_saturated, "stopped result has timer fields")

    // Without clamping the compare value is half the period.
    `SPSL_ASSERT_IMP(a_half_period, i_clk, i_rst_n, i_out_valid && i_timer_run && !i_saturated, i_cmp == ((i_arr >> 1) + TIMER_BITS'(i_arr[0])), "compare is not half the period")

endmodule

bind stepper_position_speed_loop_unit spsl_checker #(
    .TIMER_BITS (TIMER_BITS)
) u_spsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_in_opcode (i_cmd.opcode),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_timer_run (o_res.timer_run),
    .i_direction (o_res.direction),
    .i_psc       (o_res.prescaler_value),
    .i_arr       (o_res.autoreload_value),
    .i_cmp       (o_res.compare_value),
    .i_saturated (o_res.saturated)
);

### verif/spsl_loop_checker.sv
`timescale 1ns / 1ps
// Checker for the stepper position and speed loop: tracks register writes, predicts timer settings.
// Depends on spsl_pkg and the channel interfaces in spsl_if.
module spsl_loop_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    spsl_in_if                          i_cmd,
    spsl_out_if                         i_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spsl_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          o_errors,
    output int                          o_pending
);
    import spsl_pkg::*;

    localparam int TW = TIMER_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic          run;
        logic          dir;
        logic [TW-1:0] psc;
        logic [TW-1:0] arr;
        logic [TW-1:0] cmp;
        logic [31:0]   spd;
        logic          sat;
    } t_timer_set;

    t_timer_set timer_q[$];

    // Register copies
    longint          neutral;
    longint unsigned tol, gain, max_spd, step_lim, min_spd, clk_const, base_per;
    // Loop state
    logic   pos_mode;
    longint pos_cmd, speed_goal, last_speed;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_sym(longint v, longint unsigned lim);
        longint l;
        l = longint'(lim);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic t_timer_set timer_settings(longint cmd);
        t_timer_set      r;
        longint unsigned tmax, bp, num, mag, pre, period, arr, cmp;
        logic            sat;
        tmax = (64'd1 << TW) - 1;
        bp   = (base_per != 0) ? base_per : 64'd1;
        num  = clk_const << FB;
        sat  = 1'b0;
        r     = '0;
        r.spd = cmd[31:0];
        if (cmd >= -longint'(min_spd) && cmd <= longint'(min_spd)) return r;
        r.run  = 1'b1;
        r.dir  = cmd > 0;
        mag    = (cmd < 0) ? longint'(-cmd) : longint'(cmd);
        pre    = round_div(num, mag * bp);
        period = bp;
        // Prescaler too large for the timer: widen the period and recompute.
        if (pre > tmax) begin
            period = ((pre >> TW) + 1) * bp;
            pre    = round_div(num, mag * period);
        end
        if (pre == 0) begin
            r.psc = '0;
            sat   = 1'b1;
        end else if (pre - 1 > tmax) begin
            r.psc = tmax[TW-1:0];
            sat   = 1'b1;
        end else begin
            r.psc = TW'(pre - 1);
        end
        arr = period - 1;
        if (arr > tmax) begin
            arr = tmax;
            sat = 1'b1;
        end
        cmp = period / 2;
        if (cmp > tmax) begin
            cmp = tmax;
            sat = 1'b1;
        end
        r.arr = arr[TW-1:0];
        r.cmp = cmp[TW-1:0];
        r.sat = sat;
        return r;
    endfunction

    task automatic run_command(logic [2:0] opc, logic [31:0] value, logic [31:0] meas_raw);
        longint val, meas, err, p, m, q;
        val  = longint'(signed'(value));
        meas = longint'(signed'(meas_raw));
        case (opc)
            OP_TICK: begin
                if (pos_mode) begin
                    err = meas - pos_cmd;
                    if (err < longint'(tol) && err > -longint'(tol)) begin
                        speed_goal = 0;
                    end else begin
                        p = -err * longint'(gain);
                        m = (p < 0) ? -p : p;
                        m = (m + (64'sd1 <<< (FB - 1))) >>> FB;
                        q = (p < 0) ? -m : m;
                        speed_goal = clamp_sym(q, max_spd);
                    end
                end
                last_speed = last_speed + clamp_sym(speed_goal - last_speed, step_lim);
                timer_q.push_back(timer_settings(last_speed));
            end
            OP_SET_ANGLE: begin
                pos_mode = 1'b1;
                pos_cmd  = sat32(val + neutral);
            end
            OP_SET_SPEED: begin
                pos_mode   = 1'b0;
                speed_goal = val;
            end
            OP_MOVE_BY: begin
                if (!pos_mode) begin
                    pos_mode = 1'b1;
                    pos_cmd  = meas;
                end
                pos_cmd = sat32(pos_cmd + val);
            end
            OP_STOP: begin
                last_speed = 0;
                speed_goal = 0;
                pos_cmd    = meas;
                timer_q.push_back(timer_settings(0));
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t: MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        o_errors++;
    endtask

    task automatic compare_result(t_timer_set got);
        t_timer_set want;
        if (timer_q.size() == 0) begin
            report_mismatch("unexpected result", got.spd, 0);
            return;
        end
        want = timer_q.pop_front();
        if (got.run != want.run) report_mismatch("timer_run", got.run, want.run);
        if (got.dir != want.dir) report_mismatch("direction", got.dir, want.dir);
        if (got.psc != want.psc) report_mismatch("prescaler_value", got.psc, want.psc);
        if (got.arr != want.arr) report_mismatch("autoreload_value", got.arr, want.arr);
        if (got.cmp != want.cmp) report_mismatch("compare_value", got.cmp, want.cmp);
        if (got.spd != want.spd) report_mismatch("speed_command", got.spd, want.spd);
        if (got.sat != want.sat) report_mismatch("saturated", got.sat, want.sat);
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timer_q.delete();
            pos_mode   = 1'b1;
            pos_cmd    = 0;
            speed_goal = 0;
            last_speed = 0;
            neutral    = longint'(signed'(RST_ANGLE_OFFSET));
            tol        = RST_POS_TOL;
            gain       = RST_POS_GAIN;
            max_spd    = RST_MAX_SPEED;
            step_lim   = RST_STEP_LIMIT;
            min_spd    = RST_MIN_SPEED;
            clk_const  = RST_CLOCK_CONST;
            base_per   = RST_BASE_PERIOD;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_ANGLE_OFFSET:  neutral   = longint'(signed'(pwdata));
                    REG_POS_TOL:       tol       = pwdata[30:0];
                    REG_POS_GAIN:      gain      = pwdata[15:0];
                    REG_MAX_SPEED:     max_spd   = pwdata[30:0];
                    REG_STEP_LIMIT:    step_lim  = pwdata[30:0];
                    REG_MIN_SPEED:     min_spd   = pwdata[30:0];
                    REG_CLOCK_CONST:   clk_const = pwdata;
                    REG_BASE_PERIOD:   base_per  = pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready)
                compare_result('{i_res.timer_run, i_res.direction, i_res.prescaler_value,
                                 i_res.autoreload_value, i_res.compare_value,
                                 i_res.speed_command, i_res.saturated});
            if (i_cmd.valid && i_cmd.ready)
                run_command(i_cmd.opcode, i_cmd.value, i_cmd.measured_angle);
        end
        o_pending <= timer_q.size();
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the stepper position and speed loop testbench: clock, reset, command stimulus,
// register writes and the verdict. Depends on spsl_pkg, spsl_if and spsl_loop_checker.
module tb_top;
    import spsl_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_WAIT  = 400;
    localparam int LONG_HOLD    = 700;
    localparam int PHASE_ITEMS  = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          errors, pending;
    int          idle_cycles;
    bit          quiet;
    bit          hold_now;
    longint      anchor;

    spsl_in_if  cmd_ch ();
    spsl_out_if res_ch ();

    stepper_position_speed_loop_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    spsl_loop_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_ch),
        .i_res     (res_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random stall bursts, one long hold-off on request, steady in the quiet part.
    initial begin
        bit held;
        held = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_now && !held) begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(0, 11)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_cmd(logic [2:0] opc, logic [31:0] value, logic [31:0] meas);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.opcode         <= opc;
        cmd_ch.value          <= value;
        cmd_ch.measured_angle <= meas;
        @(negedge i_clk);
        while (!cmd_ch.ready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // Holds the sender off until every result is in, then lets any trailing work finish.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_settings(logic [31:0] na, logic [31:0] tl, logic [31:0] gn,
                                 logic [31:0] mx, logic [31:0] sl, logic [31:0] mn,
                                 logic [31:0] kc, logic [31:0] bp);
        write_reg(REG_ANGLE_OFFSET, na);
        write_reg(REG_POS_TOL, tl);
        write_reg(REG_POS_GAIN, gn);
        write_reg(REG_MAX_SPEED, mx);
        write_reg(REG_STEP_LIMIT, sl);
        write_reg(REG_MIN_SPEED, mn);
        write_reg(REG_CLOCK_CONST, kc);
        write_reg(REG_BASE_PERIOD, bp);
    endtask

    function automatic logic [31:0] near_anchor();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'(anchor + longint'($urandom_range(0, 1 << 22)) - (1 << 21));
    endfunction

    // Mostly ticks mixed with targets, moves, speed commands and stops, plus some noise.
    task automatic random_phase(int count);
        int       n, k;
        t_opcode  op;
        n = 0;
        while (n < count) begin
            k = $urandom_range(0, 19);
            if (k == 0) begin
                send_cmd(3'($urandom_range(5, 7)), $urandom, $urandom);
            end else begin
                if (k < 4)       op = OP_SET_ANGLE;
                else if (k < 6)  op = OP_SET_SPEED;
                else if (k < 8)  op = OP_MOVE_BY;
                else if (k < 9)  op = OP_STOP;
                else             op = OP_TICK;
                if ($urandom_range(0, 30) == 0) anchor = longint'(signed'($urandom));
                case (op)
                    OP_SET_SPEED: send_cmd(op, ($urandom_range(0, 3) == 0) ? $urandom :
                                           32'($urandom_range(0, 1 << 20)) - (1 << 19),
                                           $urandom);
                    OP_MOVE_BY:   send_cmd(op, 32'($urandom_range(0, 1 << 22)) - (1 << 21),
                                           near_anchor());
                    default:      send_cmd(op, near_anchor(), near_anchor());
                endcase
                n++;
            end
        end
    endtask

    initial begin
        quiet    = 1'b0;
        hold_now = 1'b0;
        anchor   = 0;
        i_rst_n  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        idle_cycles <= 0;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.opcode         <= OP_TICK;
        cmd_ch.value          <= '0;
        cmd_ch.measured_angle <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with reset settings: deadband, acceleration, saturation, mode changes.
        send_cmd(OP_TICK, 32'd0, 32'd0);
        send_cmd(OP_SET_ANGLE, 32'd655360, 32'd0);
        repeat (3) send_cmd(OP_TICK, 32'd0, 32'd0);
        send_cmd(OP_TICK, 32'd0, 32'h8000_0000);
        send_cmd(OP_TICK, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_cmd(OP_SET_ANGLE, 32'h7FFF_FFFF, 32'd0);
        send_cmd(OP_MOVE_BY, 32'h7FFF_FFFF, 32'd0);
        send_cmd(OP_MOVE_BY, 32'h8000_0000, 32'd0);
        send_cmd(OP_MOVE_BY, 32'h8000_0000, 32'd0);
        send_cmd(OP_TICK, 32'd0, 32'd0);
        send_cmd(OP_SET_SPEED, 32'h7FFF_FFFF, 32'd0);
        send_cmd(OP_TICK, 32'd0, 32'd0);
        send_cmd(OP_SET_SPEED, 32'h8000_0000, 32'd0);
        send_cmd(OP_TICK, 32'd0, 32'd0);
        send_cmd(OP_MOVE_BY, 32'd65536, 32'hFFF0_0000);
        send_cmd(OP_TICK, 32'd0, 32'hFFF0_0000);
        send_cmd(OP_STOP, 32'hFFFF_FFFF, 32'h8000_0000);
        send_cmd(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(3'd6, 32'd0, 32'd0);
        send_cmd(3'd7, 32'h5555_5555, 32'hAAAA_AAAA);
        wait_drained();

        // Extremes: largest offsets and limits, zero base period, tiny speed that widens.
        load_settings(32'h7FFF_FFFF, 32'd0, 32'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'd0, 32'hFFFF_FFFF, 32'd0);
        send_cmd(OP_SET_ANGLE, 32'h7FFF_FFFF, 32'd0);
        send_cmd(OP_TICK, 32'd0, 32'h8000_0000);
        send_cmd(OP_SET_SPEED, 32'd1, 32'd0);
        send_cmd(OP_TICK, 32'd0, 32'd0);
        send_cmd(OP_SET_SPEED, 32'hFFFF_FFFF, 32'd0);
        send_cmd(OP_TICK, 32'd0, 32'd0);
        random_phase(PHASE_ITEMS / 2);
        wait_drained();

        load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd1, 32'h7FFF_FFFF,
                      32'd1, 32'hFFFF);
        send_cmd(OP_SET_ANGLE, 32'h8000_0000, 32'd0);
        send_cmd(OP_TICK, 32'd0, 32'd0);
        random_phase(PHASE_ITEMS / 4);
        wait_drained();

        // Tiny clock constant against a large speed drives the prescaler to zero.
        load_settings(32'd0, 32'd0, 32'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0,
                      32'd1, 32'd1);
        send_cmd(OP_SET_SPEED, 32'h7FFF_0000, 32'd0);
        send_cmd(OP_TICK, 32'd0, 32'd0);
        random_phase(PHASE_ITEMS / 4);
        wait_drained();

        load_settings(32'd0, 32'd65536, 32'd1311, 32'd327680, 32'd6554, 32'd655,
                      32'd100000, 32'd10);
        hold_now = 1'b1;
        random_phase(PHASE_ITEMS);
        wait_drained();

        repeat (3) begin
            load_settings($urandom, $urandom_range(0, 1 << 20), $urandom_range(0, 65535),
                          $urandom_range(0, 1 << 23), $urandom_range(1, 1 << 18),
                          $urandom_range(0, 1 << 14), $urandom_range(1, 32'hFFFF_FFFF),
                          $urandom_range(1, 65535));
            random_phase(PHASE_ITEMS);
            wait_drained();
        end

        load_settings(32'd0, 32'd32768, 32'd20000, 32'd3000000, 32'd50000, 32'd100,
                      32'd2000000, 32'd100);
        quiet = 1'b1;
        random_phase(PHASE_ITEMS / 2);
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
